// ----- sv/i2cram_pkg.sv -----
// Shared constants and types for the I2C register-access master.
package i2cram_pkg;

  // Default write buffer depth and reset value of the half-period register
  localparam int unsigned MAX_LEN_DEF     = 16;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd250;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;

  // Input beat opcodes, carried in in_tuser
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_START_WR = 2'd1;
  localparam logic [1:0] OP_START_RD = 2'd2;
  localparam logic [1:0] OP_PUSH     = 2'd3;

  // Sticky status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUS_BUSY = 2'd1;
  localparam logic [1:0] ST_BUS_ERR  = 2'd2;
  localparam logic [1:0] ST_NO_ACK   = 2'd3;

  // One result beat as held in the output register and the skid stage
  typedef struct packed {
    logic [OUT_DATA_W-1:0] tdata;
    logic                  tlast;
    logic                  tuser;
  } out_beat_t;

  // Keep the first error code of a transaction
  function automatic logic [1:0] flag_f(input logic [1:0] cur, input logic [1:0] code);
    flag_f = (cur == ST_OK) ? code : cur;
  endfunction

endpackage

// ----- sv/i2c_register_access_master.sv -----
// Top level of the open-drain I2C register-access master.
//
// Open-drain I2C master for device register reads and writes. Every input beat is either a
// clock tick (which carries the sampled SDA level) or a command: start a write, start a read,
// or push one byte into the write buffer. Commands are honored only while no transaction is
// running, and a command never counts as a tick. Every input beat yields exactly one result
// beat with the SCL/SDA drive levels, any byte just received and the sticky status. The block
// takes one input beat per clock while its skid stage is empty. Its result is held in an output
// register; a one-entry skid stage lets one more beat enter while a result is stalled.
// The bus rate is set by half_period_ticks: each bus step lasts that many tick beats (zero acts
// as one); a written data bit takes three steps, a read bit two. The write buffer holds MAX_LEN
// bytes in registers and needs no clearing pass after reset.
module i2c_register_access_master #(
  parameter int unsigned MAX_LEN = i2cram_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: half_period_ticks
  input  logic                              cfg_wr_en,
  input  logic [15:0]                       cfg_wr_data,
  // in_tdata from bit 0: dev_addr[6:0], reg_addr[7:0], byte_count[4:0], wr_byte[7:0], sda_in
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cram_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: opcode[1:0]
  input  logic [i2cram_pkg::IN_USER_W-1:0]  in_tuser,
  // out_tdata from bit 0: scl_out, sda_out, rd_byte[7:0], busy_res, done_res, status[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cram_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tlast: rd_last
  output logic                              out_tlast,
  // out_tuser: rd_valid
  output logic                              out_tuser
);
  import i2cram_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned PTR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned BIDX_W = $clog2(MAX_LEN + 4);

  // Bus sequencer phases
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_S0    = 5'd1;
  localparam logic [4:0] PH_S1    = 5'd2;
  localparam logic [4:0] PH_S2    = 5'd3;
  localparam logic [4:0] PH_S3    = 5'd4;
  localparam logic [4:0] PH_BSET  = 5'd5;
  localparam logic [4:0] PH_BHIGH = 5'd6;
  localparam logic [4:0] PH_BLOW  = 5'd7;
  localparam logic [4:0] PH_AREL  = 5'd8;
  localparam logic [4:0] PH_AHIGH = 5'd9;
  localparam logic [4:0] PH_RHIGH = 5'd10;
  localparam logic [4:0] PH_RLOW  = 5'd11;
  localparam logic [4:0] PH_K0    = 5'd12;
  localparam logic [4:0] PH_K1    = 5'd13;
  localparam logic [4:0] PH_K2    = 5'd14;
  localparam logic [4:0] PH_P0    = 5'd15;
  localparam logic [4:0] PH_P1    = 5'd16;
  localparam logic [4:0] PH_P2    = 5'd17;

  // Input fields
  logic [6:0] f_dev_addr;
  logic [7:0] f_reg_addr;
  logic [4:0] f_byte_count;
  logic [7:0] f_wr_byte;
  logic       f_sda;

  assign f_dev_addr   = in_tdata[6:0];
  assign f_reg_addr   = in_tdata[14:7];
  assign f_byte_count = in_tdata[19:15];
  assign f_wr_byte    = in_tdata[27:20];
  assign f_sda        = in_tdata[28];

  // State registers
  logic [15:0]       hp_r;
  logic [4:0]        phase_r, phase_nxt;
  logic [15:0]       tc_r, tc_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [BIDX_W-1:0] bi_r, bi_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [6:0]        addr_r, addr_nxt;
  logic [7:0]        reg_r, reg_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              rd_r, rd_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;

  logic [7:0] wbuf [MAX_LEN];

  // Output register and skid stage
  out_beat_t out_r, skid_r, res;
  logic      out_valid_r, skid_valid_r;
  logic      in_fire, out_pop;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_pop   = out_valid_r && out_tready;

  // Next step after an acknowledge or a sent NACK/ACK bit
  logic [BIDX_W-1:0] ab_bi, ab_d, len_x, fill_x;
  logic [4:0]        ab_ph;
  logic              ab_load;
  logic [7:0]        ab_shift;

  assign len_x  = BIDX_W'(len_r);
  assign fill_x = BIDX_W'(fill_r);
  assign ab_bi  = bi_r + BIDX_W'(1);
  assign ab_d   = ab_bi - BIDX_W'(2);

  always_comb begin
    ab_ph    = PH_P0;
    ab_load  = 1'b0;
    ab_shift = 8'h00;
    if (ab_bi == BIDX_W'(1)) begin
      ab_ph    = PH_BSET;
      ab_load  = 1'b1;
      ab_shift = reg_r;
    end else if (!rd_r) begin
      if (ab_bi < len_x + BIDX_W'(2)) begin
        ab_ph    = PH_BSET;
        ab_load  = 1'b1;
        // bytes past the buffered count go out as zero
        ab_shift = (ab_bi < fill_x + BIDX_W'(2)) ? wbuf[ab_d[PTR_W-1:0]] : 8'h00;
      end
    end else if (ab_bi == BIDX_W'(2)) begin
      ab_ph = PH_S0;
    end else if (ab_bi < len_x + BIDX_W'(3)) begin
      ab_ph   = PH_RHIGH;
      ab_load = 1'b1;
    end
  end

  // One step of the sequencer for the accepted beat
  logic        go, push_we, ev_valid, ev_last, ev_done;
  logic [4:0]  go_ph;
  logic [7:0]  ev_byte;
  logic [15:0] hp_eff, tc_inc;

  assign hp_eff = (hp_r == 16'd0) ? 16'd1 : hp_r;
  assign tc_inc = tc_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    tc_nxt    = tc_r;
    bit_nxt   = bit_r;
    bi_nxt    = bi_r;
    shift_nxt = shift_r;
    fill_nxt  = fill_r;
    addr_nxt  = addr_r;
    reg_nxt   = reg_r;
    len_nxt   = len_r;
    rd_nxt    = rd_r;
    stat_nxt  = stat_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    go        = 1'b0;
    go_ph     = PH_IDLE;
    push_we   = 1'b0;
    ev_valid  = 1'b0;
    ev_last   = 1'b0;
    ev_byte   = 8'h00;
    ev_done   = 1'b0;

    if (in_fire) begin
      unique case (in_tuser)
        OP_START_WR, OP_START_RD: begin
          if (phase_r == PH_IDLE) begin
            addr_nxt = f_dev_addr;
            reg_nxt  = f_reg_addr;
            len_nxt  = ({27'd0, f_byte_count} > MAX_LEN) ? LEN_W'(MAX_LEN)
                                                        : LEN_W'(f_byte_count);
            rd_nxt   = (in_tuser == OP_START_RD);
            stat_nxt = ST_OK;
            bi_nxt   = '0;
            bit_nxt  = '0;
            tc_nxt   = '0;
            go       = 1'b1;
            go_ph    = PH_S0;
          end
        end
        OP_PUSH: begin
          if (phase_r == PH_IDLE && fill_r < LEN_W'(MAX_LEN)) begin
            push_we  = 1'b1;
            fill_nxt = fill_r + LEN_W'(1);
          end
        end
        OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            tc_nxt = tc_inc;
            if (tc_inc >= hp_eff) begin
              tc_nxt = '0;
              go     = 1'b1;
              case (phase_r)
                PH_S0:    go_ph = PH_S1;
                PH_S1: begin
                  if (!f_sda) begin
                    // bus busy: skip the rest of START
                    stat_nxt  = flag_f(stat_r, ST_BUS_BUSY);
                    shift_nxt = {addr_r, (bi_r == BIDX_W'(2))};
                    bit_nxt   = '0;
                    go_ph     = PH_BSET;
                  end else begin
                    go_ph = PH_S2;
                  end
                end
                PH_S2:    go_ph = PH_S3;
                PH_S3: begin
                  if (f_sda) stat_nxt = flag_f(stat_r, ST_BUS_ERR);
                  shift_nxt = {addr_r, (bi_r == BIDX_W'(2))};
                  bit_nxt   = '0;
                  go_ph     = PH_BSET;
                end
                PH_BSET:  go_ph = PH_BHIGH;
                PH_BHIGH: go_ph = PH_BLOW;
                PH_BLOW: begin
                  if (bit_r != 3'd7) begin
                    bit_nxt = bit_r + 3'd1;
                    go_ph   = PH_BSET;
                  end else begin
                    go_ph = PH_AREL;
                  end
                end
                PH_AREL:  go_ph = PH_AHIGH;
                PH_AHIGH: begin
                  if (f_sda) stat_nxt = flag_f(stat_r, ST_NO_ACK);
                  scl_nxt = 1'b0;
                  bi_nxt  = ab_bi;
                  go_ph   = ab_ph;
                  if (ab_load) begin
                    shift_nxt = ab_shift;
                    bit_nxt   = '0;
                  end
                end
                PH_RHIGH: begin
                  shift_nxt = {shift_r[6:0], f_sda};
                  if (bit_r == 3'd7) begin
                    ev_valid = 1'b1;
                    ev_byte  = shift_nxt;
                    ev_last  = (bi_r >= len_x + BIDX_W'(2));
                  end
                  go_ph = PH_RLOW;
                end
                PH_RLOW: begin
                  if (bit_r != 3'd7) begin
                    bit_nxt = bit_r + 3'd1;
                    go_ph   = PH_RHIGH;
                  end else begin
                    go_ph = PH_K0;
                  end
                end
                PH_K0:    go_ph = PH_K1;
                PH_K1:    go_ph = PH_K2;
                PH_K2: begin
                  bi_nxt = ab_bi;
                  go_ph  = ab_ph;
                  if (ab_load) begin
                    shift_nxt = ab_shift;
                    bit_nxt   = '0;
                  end
                end
                PH_P0:    go_ph = PH_P1;
                PH_P1:    go_ph = PH_P2;
                PH_P2: begin
                  ev_done = 1'b1;
                  if (!rd_r) fill_nxt = '0;
                  go_ph = PH_IDLE;
                end
                default:  go_ph = PH_IDLE;
              endcase
            end
          end
        end
        default: ;
      endcase

      // Line drive on entry to the new phase
      if (go) begin
        phase_nxt = go_ph;
        unique case (go_ph)
          PH_S0:    sda_nxt = 1'b1;
          PH_S1:    scl_nxt = 1'b1;
          PH_S2:    sda_nxt = 1'b0;
          PH_S3:    scl_nxt = 1'b0;
          PH_BSET: begin
            scl_nxt   = 1'b0;
            sda_nxt   = shift_nxt[7];
            shift_nxt = {shift_nxt[6:0], 1'b0};
          end
          PH_BHIGH: scl_nxt = 1'b1;
          PH_BLOW:  scl_nxt = 1'b0;
          PH_AREL:  sda_nxt = 1'b1;
          PH_AHIGH: scl_nxt = 1'b1;
          PH_RHIGH: begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end
          PH_RLOW:  scl_nxt = 1'b0;
          // NACK on the last byte of the read, ACK otherwise
          PH_K0:    sda_nxt = (bi_nxt >= len_x + BIDX_W'(2));
          PH_K1:    scl_nxt = 1'b1;
          PH_K2:    scl_nxt = 1'b0;
          PH_P0:    sda_nxt = 1'b0;
          PH_P1:    scl_nxt = 1'b1;
          PH_P2:    sda_nxt = 1'b1;
          default: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result beat
  always_comb begin
    res.tdata = {2'b00, stat_nxt, ev_done, (phase_nxt != PH_IDLE), ev_byte, sda_nxt, scl_nxt};
    res.tlast = ev_last;
    res.tuser = ev_valid;
  end

  // Control and bus state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r    <= HALF_PERIOD_RST;
      phase_r <= PH_IDLE;
      tc_r    <= '0;
      bit_r   <= '0;
      bi_r    <= '0;
      shift_r <= '0;
      fill_r  <= '0;
      addr_r  <= '0;
      reg_r   <= '0;
      len_r   <= '0;
      rd_r    <= 1'b0;
      stat_r  <= ST_OK;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else begin
      if (cfg_wr_en) hp_r <= cfg_wr_data;
      phase_r <= phase_nxt;
      tc_r    <= tc_nxt;
      bit_r   <= bit_nxt;
      bi_r    <= bi_nxt;
      shift_r <= shift_nxt;
      fill_r  <= fill_nxt;
      addr_r  <= addr_nxt;
      reg_r   <= reg_nxt;
      len_r   <= len_nxt;
      rd_r    <= rd_nxt;
      stat_r  <= stat_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  // Write buffer
  always_ff @(posedge clk) begin
    if (push_we) wbuf[fill_r[PTR_W-1:0]] <= f_wr_byte;
  end

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_pop) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) out_r <= skid_r;
    end else if (in_fire) begin
      if (!out_valid_r || out_pop) out_r <= res;
      else skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.tdata;
  assign out_tlast  = out_r.tlast;
  assign out_tuser  = out_r.tuser;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the output register is empty");

  a_start_enters_s0: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_IDLE && (in_tuser == OP_START_WR || in_tuser == OP_START_RD)
    |=> phase_r == PH_S0)
    else $error("start command while idle did not begin a START condition");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == OP_PUSH && phase_r == PH_IDLE && fill_r < LEN_W'(MAX_LEN)
    |=> fill_r == $past(fill_r) + LEN_W'(1))
    else $error("accepted push did not advance the write buffer count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> fill_r <= LEN_W'(MAX_LEN))
    else $error("write buffer count beyond its depth");

endmodule
